@@ hdl/fpd_pkg.sv @@
package fpd_pkg;

  // Default configuration of the block.
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // Arctangent table geometry: up to 24 entries, indexed by 5 bits.
  localparam int ATAN_LEN   = 24;
  localparam int ATAN_IDX_W = 5;

  // Angles are integers with pi = 2^30, held in 32 signed bits.
  localparam int ANGLE_W = 32;
  localparam logic signed [ANGLE_W-1:0] ANGLE_HALF_PI = 32'sd536870912;

  // Product pre-scale before the rotation (times 256).
  localparam int PRE_SHIFT = 8;

  // Output phase step is signed Q1.15.
  localparam int PHASE_W = 16;
  localparam int ROUND_SHIFT = 15;
  localparam logic signed [ANGLE_W:0] ROUND_BIAS = 33'sd16384;
  localparam logic signed [PHASE_W-1:0] PHASE_MAX = 16'sh7fff;
  localparam logic signed [PHASE_W-1:0] PHASE_MIN = 16'sh8000;

  // round(atan(2^-k) / pi * 2^30) for step k.
  function automatic logic signed [ANGLE_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] k);
    logic signed [ANGLE_W-1:0] v;
    case (k)
      5'd0:    v = 32'sd268435456;
      5'd1:    v = 32'sd158466703;
      5'd2:    v = 32'sd83729454;
      5'd3:    v = 32'sd42502378;
      5'd4:    v = 32'sd21333666;
      5'd5:    v = 32'sd10677233;
      5'd6:    v = 32'sd5339919;
      5'd7:    v = 32'sd2670123;
      5'd8:    v = 32'sd1335082;
      5'd9:    v = 32'sd667543;
      5'd10:   v = 32'sd333772;
      5'd11:   v = 32'sd166886;
      5'd12:   v = 32'sd83443;
      5'd13:   v = 32'sd41722;
      5'd14:   v = 32'sd20861;
      5'd15:   v = 32'sd10430;
      5'd16:   v = 32'sd5215;
      5'd17:   v = 32'sd2608;
      5'd18:   v = 32'sd1304;
      5'd19:   v = 32'sd652;
      5'd20:   v = 32'sd326;
      5'd21:   v = 32'sd163;
      5'd22:   v = 32'sd81;
      5'd23:   v = 32'sd41;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/fm_polar_discriminator_unit.sv @@
// Polar discriminator for complex baseband: each input transfer carries one
// sample (I in s_tdata bits [W-1:0], Q in bits [2W-1:W]) and a burst marker
// on s_tlast. Each sample is multiplied by the conjugate of the previous one
// and the angle of that product is returned as phase step / pi in signed
// Q1.15 on m_tdata, with s_tlast copied to m_tlast. Exactly one output
// transfer follows every input transfer, in order.
// The complex multiply forms four products on one shared multiplier, then
// the CORDIC unit loads, runs its steps and rounds. A new sample is taken
// only once the previous one is through: s_tready is high only while no
// sample is in flight.
// The result sits in an output register, so a new sample is taken while the
// previous result waits for m_tready. If the receiver still stalls when the
// next result is ready, that result is held inside and s_tready stays low.
// Reset clears the previous sample to zero, so the first result is 0, and
// empties the output register.
module fm_polar_discriminator_unit #(
  parameter int SAMPLE_WIDTH = fpd_pkg::SAMPLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = fpd_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         s_tvalid,
  output logic                                         s_tready,
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]          s_tdata,  // sample_i, sample_q
  input  logic                                         s_tlast,  // last_in
  output logic                                         m_tvalid,
  input  logic                                         m_tready,
  output logic [fpd_pkg::PHASE_W-1:0]                  m_tdata,  // phase_step
  output logic                                         m_tlast   // last_out
);
  import fpd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_MUL    = 4'b0010,
    S_CORDIC = 4'b0100,
    S_HOLD   = 4'b1000
  } top_state_t;

  top_state_t state;

  logic signed [SAMPLE_WIDTH-1:0] prev_i;
  logic signed [SAMPLE_WIDTH-1:0] prev_q;
  logic signed [SAMPLE_WIDTH-1:0] old_i;
  logic signed [SAMPLE_WIDTH-1:0] old_q;
  logic                           last_r;

  logic                           in_xfer;
  logic                           out_free;
  logic                           mul_done;
  logic signed [2*SAMPLE_WIDTH:0] prod_re;
  logic signed [2*SAMPLE_WIDTH:0] prod_im;
  logic                           cordic_done;
  logic signed [PHASE_W-1:0]      cordic_phase;
  logic                           load_out;

  assign s_tready = (state == S_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign load_out = ((state == S_CORDIC) && cordic_done && out_free) ||
                    ((state == S_HOLD) && out_free);

  // Sample history: the accepted sample becomes the new previous sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_i <= '0;
      prev_q <= '0;
    end else if (in_xfer) begin
      prev_i <= s_tdata[SAMPLE_WIDTH-1:0];
      prev_q <= s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      old_i  <= prev_i;
      old_q  <= prev_q;
      last_r <= s_tlast;
    end
  end

  fpd_cmul #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_cmul (
    .clk   (clk),
    .rst   (rst),
    .start (in_xfer),
    .cur_i (prev_i),
    .cur_q (prev_q),
    .old_i (old_i),
    .old_q (old_q),
    .done  (mul_done),
    .re    (prod_re),
    .im    (prod_im)
  );

  fpd_cordic #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (mul_done),
    .re    (prod_re),
    .im    (prod_im),
    .done  (cordic_done),
    .phase (cordic_phase)
  );

  // Item sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            state <= S_CORDIC;
          end
        end
        S_CORDIC: begin
          if (cordic_done) begin
            state <= out_free ? S_IDLE : S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= cordic_phase;
      m_tlast <= last_r;
    end
  end

  // A sample in flight blocks the input until its result is stored.
  assert property (@(posedge clk) disable iff (rst) in_xfer |=> !s_tready)
    else $error("input taken while a sample is in flight");

  // The multiply and CORDIC phases never finish in the same cycle.
  assert property (@(posedge clk) disable iff (rst) !(mul_done && cordic_done))
    else $error("multiply and CORDIC completed together");

  // The CORDIC unit only completes while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst) cordic_done |-> (state == S_CORDIC))
    else $error("CORDIC completion outside its phase");

  // A stored result is never overwritten while the receiver stalls.
  assert property (@(posedge clk) disable iff (rst)
                   (m_tvalid && !m_tready) |-> !load_out)
    else $error("output register overwritten during stall");

endmodule

@@ hdl/fpd_cmul.sv @@
// Complex multiply of the new sample by the conjugate of the previous one.
// One signed multiplier is shared by the four products, taken one after another;
// each product is folded into an accumulator in the same cycle.
module fpd_cmul #(
  parameter int SAMPLE_WIDTH = fpd_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [SAMPLE_WIDTH-1:0]   cur_i,
  input  logic signed [SAMPLE_WIDTH-1:0]   cur_q,
  input  logic signed [SAMPLE_WIDTH-1:0]   old_i,
  input  logic signed [SAMPLE_WIDTH-1:0]   old_q,
  output logic                             done,
  output logic signed [2*SAMPLE_WIDTH:0]   re,
  output logic signed [2*SAMPLE_WIDTH:0]   im
);
  import fpd_pkg::*;

  localparam int MW = 2 * SAMPLE_WIDTH;
  localparam int PW = MW + 1;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_II   = 5'b00010,
    PH_QQ   = 5'b00100,
    PH_QI   = 5'b01000,
    PH_IQ   = 5'b10000
  } cmul_phase_t;

  cmul_phase_t phase;
  cmul_phase_t phase_next;

  logic signed [SAMPLE_WIDTH-1:0] mul_a;
  logic signed [SAMPLE_WIDTH-1:0] mul_b;
  logic signed [MW-1:0]           prod;
  logic signed [PW-1:0]           prod_ext;
  logic signed [PW-1:0]           acc;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = cur_i;
    mul_b = old_i;
    phase_next = phase;
    unique case (phase)
      PH_IDLE: begin
        if (start) begin
          phase_next = PH_II;
        end
      end
      PH_II: begin
        mul_a = cur_i;
        mul_b = old_i;
        phase_next = PH_QQ;
      end
      PH_QQ: begin
        mul_a = cur_q;
        mul_b = old_q;
        phase_next = PH_QI;
      end
      PH_QI: begin
        mul_a = cur_q;
        mul_b = old_i;
        phase_next = PH_IQ;
      end
      PH_IQ: begin
        mul_a = cur_i;
        mul_b = old_q;
        phase_next = PH_IDLE;
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_ext = PW'(prod);

  // Sequencer state and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= (phase == PH_IQ);
    end
  end

  // Accumulate: re = ii + qq, im = qi - iq.
  always_ff @(posedge clk) begin
    case (phase)
      PH_II:   acc <= prod_ext;
      PH_QQ:   re  <= acc + prod_ext;
      PH_QI:   acc <= prod_ext;
      PH_IQ:   im  <= acc - prod_ext;
      default: acc <= acc;
    endcase
  end

endmodule

@@ hdl/fpd_cordic.sv @@
// Iterative CORDIC vectoring unit. One shift-and-add step per cycle drives
// the vector onto the real axis while the angle register collects the turn.
module fpd_cordic #(
  parameter int SAMPLE_WIDTH = fpd_pkg::SAMPLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = fpd_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [2*SAMPLE_WIDTH:0]        re,
  input  logic signed [2*SAMPLE_WIDTH:0]        im,
  output logic                                  done,
  output logic signed [fpd_pkg::PHASE_W-1:0]    phase
);
  import fpd_pkg::*;

  // Room for the pre-scale, a quadrant turn and the CORDIC gain.
  localparam int XW = 2 * SAMPLE_WIDTH + 10;

  typedef enum logic [2:0] {
    C_IDLE  = 3'b001,
    C_ITER  = 3'b010,
    C_ROUND = 3'b100
  } cordic_state_t;

  cordic_state_t state;

  logic signed [XW-1:0]      x;
  logic signed [XW-1:0]      y;
  logic signed [ANGLE_W-1:0] z;
  logic [ATAN_IDX_W-1:0]     k;
  logic                      zero_vec;

  logic signed [XW-1:0]      x_pre;
  logic signed [XW-1:0]      y_pre;
  logic signed [XW-1:0]      dx;
  logic signed [XW-1:0]      dy;
  logic signed [ANGLE_W-1:0] step_angle;
  logic signed [ANGLE_W:0]   z_biased;
  logic signed [ANGLE_W-ROUND_SHIFT:0] z_round;
  logic signed [PHASE_W-1:0] phase_sat;

  assign x_pre = XW'(re) <<< PRE_SHIFT;
  assign y_pre = XW'(im) <<< PRE_SHIFT;

  assign dx         = y >>> k;
  assign dy         = x >>> k;
  assign step_angle = atan_entry(k);

  // Round to Q1.15 and saturate.
  always_comb begin
    z_biased = (ANGLE_W + 1)'(z) + ROUND_BIAS;
    z_round  = (ANGLE_W - ROUND_SHIFT + 1)'(z_biased >>> ROUND_SHIFT);
    if (z_round > (ANGLE_W - ROUND_SHIFT + 1)'(PHASE_MAX)) begin
      phase_sat = PHASE_MAX;
    end else if (z_round < (ANGLE_W - ROUND_SHIFT + 1)'(PHASE_MIN)) begin
      phase_sat = PHASE_MIN;
    end else begin
      phase_sat = PHASE_W'(z_round);
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        C_IDLE: begin
          if (start) begin
            state <= C_ITER;
          end
        end
        C_ITER: begin
          if (k == ATAN_IDX_W'(CORDIC_STEPS - 1)) begin
            state <= C_ROUND;
          end
        end
        C_ROUND: begin
          state <= C_IDLE;
          done  <= 1'b1;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  // Datapath: load with quadrant fix, iterate, then round.
  always_ff @(posedge clk) begin
    case (state)
      C_IDLE: begin
        if (start) begin
          k        <= '0;
          zero_vec <= (re == '0) && (im == '0);
          if (x_pre[XW-1]) begin
            if (!y_pre[XW-1]) begin
              x <= y_pre;
              y <= -x_pre;
              z <= ANGLE_HALF_PI;
            end else begin
              x <= -y_pre;
              y <= x_pre;
              z <= -ANGLE_HALF_PI;
            end
          end else begin
            x <= x_pre;
            y <= y_pre;
            z <= '0;
          end
        end
      end
      C_ITER: begin
        k <= k + 1'b1;
        if (!y[XW-1]) begin
          x <= x + dx;
          y <= y - dy;
          z <= z + step_angle;
        end else begin
          x <= x - dx;
          y <= y + dy;
          z <= z - step_angle;
        end
      end
      C_ROUND: begin
        phase <= zero_vec ? '0 : phase_sat;
      end
      default: k <= k;
    endcase
  end

endmodule

@@ test/fm_polar_discriminator_unit_test.sv @@
`timescale 1ns / 100ps

module fm_polar_discriminator_unit_test;

  localparam int SW        = fpd_pkg::SAMPLE_WIDTH_DEF;
  localparam int STEPS     = fpd_pkg::CORDIC_STEPS_DEF;
  localparam int DATA_W    = ((2 * SW + 7) / 8) * 8;
  localparam int PERIOD    = STEPS + 8;
  localparam int STALL_MAX = 3000;

  // Arctangent of 2^-k as a fraction of pi, with pi = 2^30.
  localparam longint ATAN_STEP [24] = '{
    268435456, 158466703, 83729454, 42502378, 21333666, 10677233,
    5339919, 2670123, 1335082, 667543, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608,
    1304, 652, 326, 163, 81, 41
  };

  typedef struct packed {
    logic signed [fpd_pkg::PHASE_W-1:0] phase;
    logic                               last;
  } phase_result_t;

  logic                        clk      = 1'b0;
  logic                        rst      = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [DATA_W-1:0]           s_tdata  = '0;  // sample_i, sample_q
  logic                        s_tlast  = 1'b0; // last_in
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [fpd_pkg::PHASE_W-1:0] m_tdata;         // phase_step
  logic                        m_tlast;         // last_out

  // Phase steps still owed by the block, oldest first.
  phase_result_t pending_phase [$];
  phase_result_t oldest_phase;

  // Previous accepted sample as seen by the predictor.
  longint last_i = 0;
  longint last_q = 0;

  int  errors      = 0;
  int  sent_count  = 0;
  int  burst_ends  = 0;
  int  pi_count    = 0;
  int  zero_count  = 0;
  int  stall_left  = 0;
  int  quiet_cycles = 0;
  bit  no_idle     = 1'b0;

  fm_polar_discriminator_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int idle_length();
    int r;
    r = $urandom_range(99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(4, 1);
    if (r < 97) return $urandom_range(16, 5);
    return $urandom_range(80, 30);
  endfunction

  // Angle of (re, im) as phase / pi in Q1.15, by vectoring CORDIC.
  function automatic logic signed [15:0] phase_of_product(longint re, longint im);
    longint x;
    longint y;
    longint z;
    longint t;
    longint dx;
    longint dy;
    longint r;
    if (re == 0 && im == 0) return '0;
    x = re * 256;
    y = im * 256;
    z = 0;
    // Fold the left half plane into the right one first.
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = longint'(fpd_pkg::ANGLE_HALF_PI);
      end else begin
        x = -y;
        y = t;
        z = -longint'(fpd_pkg::ANGLE_HALF_PI);
      end
    end
    for (int k = 0; k < STEPS && k < 24; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_STEP[k];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_STEP[k];
      end
    end
    r = (z + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  // Offer one sample, wait for its transfer, then record the phase step it owes.
  task automatic send_sample(input logic signed [15:0] si, input logic signed [15:0] sq,
                             input logic lst);
    int            gap;
    longint        re;
    longint        im;
    phase_result_t want;
    gap = idle_length();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {sq, si};
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    re = longint'(si) * last_i + longint'(sq) * last_q;
    im = longint'(sq) * last_i - longint'(si) * last_q;
    want.phase = phase_of_product(re, im);
    want.last  = lst;
    pending_phase.push_back(want);
    last_i = si;
    last_q = sq;
    sent_count++;
    if (lst) burst_ends++;
    if (want.phase == fpd_pkg::PHASE_MAX) pi_count++;
    if (want.phase == 0) zero_count++;
  endtask

  // Withdraw the input and wait until every owed result has come out.
  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    while (pending_phase.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls on m_tready.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      if (!no_idle && $urandom_range(3) == 0) stall_left <= idle_length();
    end
  end

  // Compare every output transfer with the oldest owed phase step.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_phase.size() == 0) begin
        $error("unexpected output transfer: phase_step %0d, last_out %0b",
               $signed(m_tdata), m_tlast);
        errors++;
      end else begin
        oldest_phase = pending_phase.pop_front();
        if (m_tdata !== oldest_phase.phase) begin
          $error("phase_step: expected %0d, actual %0d",
                 oldest_phase.phase, $signed(m_tdata));
          errors++;
        end
        if (m_tlast !== oldest_phase.last) begin
          $error("last_out: expected %0b, actual %0b", oldest_phase.last, m_tlast);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // The first sample after reset has a zero predecessor.
  task automatic test_first_after_reset();
    send_sample(16'sd12345, -16'sd2222, 1'b0);
  endtask

  // Extremes, quadrant steps, the angle of pi and zero samples.
  task automatic test_directed_cases();
    send_sample(16'sd1, 16'sd0, 1'b0);
    send_sample(-16'sd1, 16'sd0, 1'b1);           // step of exactly pi
    send_sample(16'sd0, 16'sd0, 1'b0);            // zero sample
    send_sample(16'sd100, 16'sd0, 1'b0);          // zero predecessor
    send_sample(16'sd32767, 16'sd32767, 1'b0);
    send_sample(-16'sd32768, -16'sd32768, 1'b1);  // pi again at full scale
    send_sample(-16'sd32768, -16'sd32768, 1'b0);  // largest real product
    send_sample(16'sd32767, -16'sd32768, 1'b0);
    send_sample(-16'sd32768, 16'sd32767, 1'b0);
    send_sample(16'sd0, 16'sd32767, 1'b0);
    send_sample(-16'sd32768, 16'sd0, 1'b0);
    send_sample(16'sd0, -16'sd32768, 1'b0);
    send_sample(16'sd32767, 16'sd0, 1'b1);
    send_sample(16'sd1, 16'sd1, 1'b0);
    send_sample(-16'sd1, -16'sd1, 1'b0);
    send_sample(16'sd1, -16'sd1, 1'b0);
    send_sample(-16'sd1, 16'sd1, 1'b0);
    send_sample(16'sd32767, 16'sd1, 1'b0);
    send_sample(16'sd32767, -16'sd1, 1'b1);
    send_sample(16'sd0, 16'sd1, 1'b0);
  endtask

  // Noise mixed with values on and near the axes, repeats and negations.
  task automatic test_random_noise(input int count);
    logic signed [15:0] si;
    logic signed [15:0] sq;
    int                 mode;
    for (int n = 0; n < count; n++) begin
      mode = $urandom_range(9);
      si   = 16'($urandom);
      sq   = 16'($urandom);
      if (mode == 0) begin
        si = 16'(last_i);
        sq = 16'(last_q);
      end else if (mode == 1) begin
        si = 16'(-last_i);
        sq = 16'(-last_q);
      end else if (mode <= 3) begin
        case ($urandom_range(5))
          0: si = 16'sd0;
          1: si = 16'sd1;
          2: si = -16'sd1;
          3: si = 16'sd32767;
          4: si = -16'sd32768;
          default: si = 16'($signed($urandom_range(16)) - 8);
        endcase
        case ($urandom_range(5))
          0: sq = 16'sd0;
          1: sq = 16'sd1;
          2: sq = -16'sd1;
          3: sq = 16'sd32767;
          4: sq = -16'sd32768;
          default: sq = 16'($signed($urandom_range(16)) - 8);
        endcase
      end
      send_sample(si, sq, $urandom_range(7) == 0);
    end
  endtask

  // Bursts of a rotating phasor with random amplitude and frequency.
  task automatic test_tone_bursts(input int count);
    real amp;
    real ph;
    real dph;
    int  len;
    int  sent;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(64, 8);
      if ($urandom_range(4) == 0) amp = $urandom_range(64, 1);
      else amp = $urandom_range(32767, 1000);
      dph = (real'($signed($urandom_range(20000))) - 10000.0) / 10000.0 * 3.14159;
      ph  = real'($urandom_range(6283)) / 1000.0;
      for (int n = 0; n < len; n++) begin
        send_sample(16'($rtoi(amp * $cos(ph))), 16'($rtoi(amp * $sin(ph))),
                    n == len - 1);
        ph = ph + dph;
      end
      sent = sent + len;
    end
  endtask

  // Samples offered without idle gaps and with no new receiver stalls.
  task automatic test_no_idle_stretch(input int count);
    no_idle = 1'b1;
    test_random_noise(count);
    no_idle = 1'b0;
  endtask

  // Let the block empty completely, then carry on from the held sample.
  task automatic test_drain_pause();
    test_random_noise(10);
    wait_for_drain();
    test_random_noise(10);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_first_after_reset();
    test_directed_cases();
    test_drain_pause();
    test_random_noise(500);
    test_tone_bursts(1100);
    test_no_idle_stretch(150);
    test_random_noise(130);

    // All stimulus is in; wait for the tail and a margin.
    wait_for_drain();
    repeat (4 * PERIOD) @(posedge clk);

    $display("Covered %0d samples in %0d bursts, with random stalls on both sides.",
             sent_count, burst_ends);
    $display("Steps of +pi: %0d, zero steps: %0d, errors: %0d.",
             pi_count, zero_count, errors);
    if (errors == 0 && pending_phase.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
